### hw/rtl/csm_pkg.sv
`default_nettype none

package csm_pkg;

    // Codes of the func field.
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    // Control that the top level broadcasts to every cell of the chain.
    typedef struct packed {
        logic text_en;  // a text word is accepted this cycle
        logic load_en;  // a pattern word is accepted this cycle
        logic flush;    // the match bits belong to a text that has ended
    } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/csm_cell.sv
`default_nettype none

module csm_cell #(
    parameter int IDX         = 0,
    parameter int LEN_W       = 6,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire csm_pkg::cell_ctl_t      ctl,
    input  wire        [LEN_W-1:0]       len,
    input  wire        [LEN_W-1:0]       wr_ptr,
    input  wire signed [VALUE_WIDTH-1:0] din,
    input  wire                          prev_in,
    output logic                         match_out,
    output logic                         hit
);

    localparam logic [LEN_W-1:0] MY_POS  = LEN_W'(IDX);
    localparam logic [LEN_W-1:0] MY_LAST = LEN_W'(IDX + 1);

    logic signed [VALUE_WIDTH-1:0] elem_reg;
    logic                          match_reg;
    logic                          match_next;
    logic                          active;

    assign active = (len > MY_POS);

    always_comb
    begin
        match_next = match_reg;
        if (ctl.text_en)
        begin
            match_next = active & prev_in & (elem_reg == din);
        end
        else if (ctl.load_en || ctl.flush)
        begin
            match_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_en && (wr_ptr == MY_POS))
        begin
            elem_reg <= din;
        end
    end

    assign match_out = match_reg;
    // Only the cell that holds the final pattern element reports a whole match.
    assign hit       = match_reg & (len == MY_LAST);

endmodule

`default_nettype wire

### hw/rtl/contiguous_subsequence_matcher_unit.sv
`default_nettype none

// Contiguous subsequence matcher. Pattern words (func = 0) are loaded one per
// cycle into a chain of MAX_PATTERN cells, each holding one pattern element
// and one partial-match bit; last = 1 closes the pattern, and the next pattern
// word starts a new one. Text words (func = 1) are taken one per cycle: every
// cell compares the word with its element and passes its match bit to the next
// cell, so the whole pattern is checked against each text position at once. The
// result for a text is registered in the match bits, then waits as pending until
// it can enter the output register, and input words keep flowing meanwhile; input
// stalls only while a finished result cannot enter the output register because
// the previous one has not been taken. An empty pattern is found in any text,
// and pattern words beyond MAX_PATTERN are dropped and flagged by
// pattern_overflow.
module contiguous_subsequence_matcher_unit #(
    parameter int MAX_PATTERN = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          func,
    input  wire signed [VALUE_WIDTH-1:0] value,
    input  wire                          last,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         found,
    output logic                         pattern_overflow
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   complete_reg, complete_next;
    logic                   ovf_reg, ovf_next;
    logic                   found_reg, found_next;
    logic                   upd_reg;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   found_out_reg;
    logic                   ovf_out_reg;

    logic                   in_acc;
    logic                   text_acc;
    logic                   load_acc;
    logic                   cap;
    logic                   found_now;
    logic [LEN_W-1:0]       wr_ptr;
    csm_pkg::cell_ctl_t     ctl;
    logic [MAX_PATTERN-1:0] match_bits;
    logic [MAX_PATTERN-1:0] chain_in;
    logic [MAX_PATTERN-1:0] hits;

    // A result moves into the output register when that register is free.
    assign cap      = pend_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~pend_reg | cap;
    assign in_acc   = in_valid & in_ready;
    assign text_acc = in_acc & (func == csm_pkg::FUNC_TEXT);
    assign load_acc = in_acc & (func == csm_pkg::FUNC_PATTERN);

    assign ctl.text_en = text_acc;
    assign ctl.load_en = load_acc;
    assign ctl.flush   = pend_reg;

    // A closed pattern is replaced from its first element.
    assign wr_ptr = complete_reg ? '0 : len_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PATTERN; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign chain_in[gi] = 1'b1;
            end
            else
            begin : g_body
                // Bits left by a text that has ended must not start a new one.
                assign chain_in[gi] = match_bits[gi-1] & ~pend_reg;
            end

            csm_cell #(
                .IDX         (gi),
                .LEN_W       (LEN_W),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .len       (len_reg),
                .wr_ptr    (wr_ptr),
                .din       (value),
                .prev_in   (chain_in[gi]),
                .match_out (match_bits[gi]),
                .hit       (hits[gi])
            );
        end
    endgenerate

    // The match bits hold a fresh text step only in the cycle after it.
    assign found_now = found_reg | (upd_reg & (|hits));

    always_comb
    begin
        len_next      = len_reg;
        complete_next = complete_reg;
        ovf_next      = ovf_reg;
        if (load_acc)
        begin
            complete_next = last;
            if (wr_ptr < MAX_LEN)
            begin
                len_next = wr_ptr + LEN_W'(1);
                ovf_next = complete_reg ? 1'b0 : ovf_reg;
            end
            else
            begin
                len_next = wr_ptr;
                ovf_next = 1'b1;
            end
        end

        if (load_acc || cap)
        begin
            found_next = 1'b0;
        end
        else
        begin
            found_next = found_now;
        end

        if (text_acc && last)
        begin
            pend_next = 1'b1;
        end
        else if (cap)
        begin
            pend_next = 1'b0;
        end
        else
        begin
            pend_next = pend_reg;
        end

        if (cap)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            complete_reg  <= 1'b0;
            ovf_reg       <= 1'b0;
            found_reg     <= 1'b0;
            upd_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            complete_reg  <= complete_next;
            ovf_reg       <= ovf_next;
            found_reg     <= found_next;
            upd_reg       <= text_acc;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            found_out_reg <= found_now | (len_reg == '0);
            ovf_out_reg   <= ovf_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign found            = found_out_reg;
    assign pattern_overflow = ovf_out_reg;

    a_len_range : assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= MAX_LEN)
        else $error("pattern length beyond the cell count");

    a_ovf_full : assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == MAX_LEN))
        else $error("overflow flagged while the chain is not full");

    a_empty_idle : assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg == '0) |-> (match_bits == '0))
        else $error("match bit set with an empty pattern");

    a_one_hit : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("more than one cell reports a whole match");

    a_end_pend : assert property (@(posedge clk) disable iff (!rst_n)
        (text_acc && last) |=> pend_reg)
        else $error("end of text not held for its result");

endmodule

`default_nettype wire
